// ===== src/sgab_pkg.sv =====
package sgab_pkg;

  localparam int OUT_W   = 21;
  localparam int COUNT_W = 17;
  localparam int RATE_W  = 17;
  localparam int GAIN_DB_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 2;
  localparam int ROM_DEPTH = 97;
  localparam int ROM_IDX_W = 7;

  // half-dB steps: user range and the automatic boost
  localparam int STEP_MAX   = 48;
  localparam int BOOST_STEP = 12;

  localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(8000);
  localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(96000);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd2;

  localparam logic CMD_FRAME   = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [STATUS_W-1:0] BOOST_UNDECIDED = 2'd0;
  localparam logic [STATUS_W-1:0] BOOST_ON        = 2'd1;
  localparam logic [STATUS_W-1:0] BOOST_DECLINED  = 2'd2;

  // 10^(r/40) scaled by 6553600, one decade
  localparam logic [25:0] DEC_ROM [40] = '{
    26'd6553600,  26'd6941925,  26'd7353260,  26'd7788968,  26'd8250494,
    26'd8739366,  26'd9257206,  26'd9805730,  26'd10386756, 26'd11002210,
    26'd11654132, 26'd12344683, 26'd13076151, 26'd13850962, 26'd14671683,
    26'd15541035, 26'd16461899, 26'd17437328, 26'd18470554, 26'd19565003,
    26'd20724303, 26'd21952295, 26'd23253050, 26'd24630880, 26'd26090341,
    26'd27636302, 26'd29273854, 26'd31008441, 26'd32845806, 26'd34792043,
    26'd36853601, 26'd39037314, 26'd41350420, 26'd43800587, 26'd46395935,
    26'd49145067, 26'd52057095, 26'd55141672, 26'd58409022, 26'd61869974
  };
  localparam logic [9:0] POW_TEN [4] = '{10'd1, 10'd10, 10'd100, 10'd1000};

  typedef struct packed {
    logic              boost_en;
    logic              dec_clr;
    logic [RATE_W-1:0] sample_rate;
  } cfg_ctl_t;

endpackage

// ===== src/sgab_cfg.sv =====
module sgab_cfg
  import sgab_pkg::*;
#(
  parameter int FRACTION_BITS = 16,
  parameter int GAIN_W        = FRACTION_BITS + 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data,
  output cfg_ctl_t             ctl,
  output logic [GAIN_W-1:0]    gain_base,
  output logic [GAIN_W-1:0]    gain_boost
);

  typedef logic [GAIN_W-1:0] rom_t [ROM_DEPTH];

  // linear gain for each half-dB step from -24 dB to +24 dB
  function automatic rom_t build_rom();
    rom_t        rom;
    int          r;
    int          d;
    logic [63:0] num;
    r = 32;
    d = 0;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      num    = (64'(DEC_ROM[r]) * 64'(POW_TEN[d])) << FRACTION_BITS;
      rom[i] = GAIN_W'((num + 64'd327680000) / 64'd655360000);
      r++;
      if (r == 40) begin
        r = 0;
        d++;
      end
    end
    return rom;
  endfunction

  localparam rom_t GAIN_ROM = build_rom();

  logic signed [GAIN_DB_W-1:0] gain_db_r, gain_db_nxt;
  logic                        boost_en_r, boost_en_nxt;
  logic [RATE_W-1:0]           rate_r, rate_nxt;
  logic                        dec_clr_r, dec_clr_nxt;
  logic [GAIN_W-1:0]           gain_base_r, gain_boost_r;

  logic signed [GAIN_DB_W-1:0] wr_db;
  logic signed [7:0]           k_boost;
  logic signed [7:0]           idx_base;
  logic signed [7:0]           idx_boost;

  always_comb begin
    wr_db = $signed(cfg_data[GAIN_DB_W-1:0]);
    gain_db_nxt = gain_db_r;
    boost_en_nxt = boost_en_r;
    rate_nxt = rate_r;
    dec_clr_nxt = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_GAIN: begin
          if (wr_db > GAIN_DB_W'(STEP_MAX))
            gain_db_nxt = GAIN_DB_W'(STEP_MAX);
          else if (wr_db < -GAIN_DB_W'(STEP_MAX))
            gain_db_nxt = -GAIN_DB_W'(STEP_MAX);
          else
            gain_db_nxt = wr_db;
        end
        CFG_BOOST_EN: begin
          boost_en_nxt = cfg_data[0];
          dec_clr_nxt = 1'b1;
        end
        CFG_RATE: begin
          if (cfg_data >= RATE_MIN && cfg_data <= RATE_MAX)
            rate_nxt = cfg_data;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    k_boost = 8'(gain_db_r) + 8'(BOOST_STEP);
    if (k_boost > 8'(STEP_MAX))
      k_boost = 8'(STEP_MAX);
    idx_base = 8'(gain_db_r) + 8'(STEP_MAX);
    idx_boost = k_boost + 8'(STEP_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_db_r <= '0;
      boost_en_r <= 1'b0;
      rate_r <= RATE_RESET;
      dec_clr_r <= 1'b0;
    end else begin
      gain_db_r <= gain_db_nxt;
      boost_en_r <= boost_en_nxt;
      rate_r <= rate_nxt;
      dec_clr_r <= dec_clr_nxt;
    end
  end

  // register the gains from the stored step in the cycle after it changes
  always_ff @(posedge clk) begin
    gain_base_r <= GAIN_ROM[idx_base[ROM_IDX_W-1:0]];
    gain_boost_r <= GAIN_ROM[idx_boost[ROM_IDX_W-1:0]];
  end

  assign ctl.boost_en = boost_en_r;
  assign ctl.dec_clr = dec_clr_r;
  assign ctl.sample_rate = rate_r;
  assign gain_base = gain_base_r;
  assign gain_boost = gain_boost_r;

endmodule

// ===== src/sgab_scale.sv =====
module sgab_scale
  import sgab_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int GAIN_W      = 20
) (
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [GAIN_W-1:0]      gain,
  output logic signed [OUT_W-1:0]       scaled,
  output logic        [OUT_W-1:0]       magnitude
);

  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int Q_W    = PROD_W - (SAMPLE_BITS - 1);
  localparam int CMP_W  = ((Q_W > OUT_W) ? Q_W : OUT_W) + 1;

  localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [CMP_W-1:0] SAT_LO = -CMP_W'(1 << (OUT_W - 1));

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shifted;
  logic signed [CMP_W-1:0]  q;

  always_comb begin
    prod = PROD_W'(sample) * $signed(PROD_W'({1'b0, gain}));
    // arithmetic shift floors toward minus infinity
    shifted = prod >>> (SAMPLE_BITS - 1);
    q = CMP_W'($signed(shifted[Q_W-1:0]));
    if (q > SAT_HI)
      scaled = SAT_HI[OUT_W-1:0];
    else if (q < SAT_LO)
      scaled = SAT_LO[OUT_W-1:0];
    else
      scaled = q[OUT_W-1:0];
    magnitude = scaled[OUT_W-1] ? (~scaled + OUT_W'(1)) : scaled;
  end

endmodule

// ===== src/stereo_gain_with_auto_boost.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      in_cmd, in_left_sample, in_right_sample,
//                                              in_block_end
// out      output     out_valid / out_ready    out_left, out_right, out_peak_level,
//                                              out_boost_status, out_last
// cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One request per cycle while the output is not stalled; a taken request enters the input
// register, then one multiply per channel carries its result into the output register.
// Gain changes from a register write reach the multipliers through the step and gain registers.
// Reset (rst_n low, synchronous) empties both stages and restores register defaults.
// A stalled result holds the output register; the input register still takes one more request.
module stereo_gain_with_auto_boost
  import sgab_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_right_sample,
  input  logic                          in_block_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       out_left,
  output logic signed [OUT_W-1:0]       out_right,
  output logic        [OUT_W-1:0]       out_peak_level,
  output logic        [STATUS_W-1:0]    out_boost_status,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [CFG_IDX_W-1:0]   cfg_index,
  input  logic        [RATE_W-1:0]      cfg_data
);

  localparam int GAIN_W = FRACTION_BITS + 4;
  localparam int PK25_W = OUT_W + 6;
  localparam logic [PK25_W-1:0] BOOST_THR = PK25_W'(2) << FRACTION_BITS;

  cfg_ctl_t          ctl;
  logic [GAIN_W-1:0] gain_base, gain_boost, gain_sel;

  // input stage
  logic                          s1_vld_r, s1_vld_nxt;
  logic                          s1_cmd_r;
  logic signed [SAMPLE_BITS-1:0] s1_left_r, s1_right_r;
  logic                          s1_last_r;

  // result stage
  logic                       out_vld_r, out_vld_nxt;
  logic signed [OUT_W-1:0]    out_left_r, out_right_r, out_left_nxt, out_right_nxt;
  logic [OUT_W-1:0]           out_peak_r, out_peak_nxt;
  logic [STATUS_W-1:0]        out_status_r, out_status_nxt;
  logic                       out_last_r, out_last_nxt;

  // running state
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [OUT_W-1:0]    peak_r, peak_nxt;
  logic [STATUS_W-1:0] dec_r, dec_nxt;

  logic signed [OUT_W-1:0] sc_left, sc_right;
  logic [OUT_W-1:0]        mag_left, mag_right, pk;
  logic [COUNT_W-1:0]      cnt_inc;
  logic [PK25_W-1:0]       pk25;
  logic                    advance, in_fire;

  sgab_cfg #(
    .FRACTION_BITS(FRACTION_BITS),
    .GAIN_W       (GAIN_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .gain_base (gain_base),
    .gain_boost(gain_boost)
  );

  assign gain_sel = (ctl.boost_en && dec_r == BOOST_ON) ? gain_boost : gain_base;

  sgab_scale #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .GAIN_W     (GAIN_W)
  ) u_scale_left (
    .sample   (s1_left_r),
    .gain     (gain_sel),
    .scaled   (sc_left),
    .magnitude(mag_left)
  );

  sgab_scale #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .GAIN_W     (GAIN_W)
  ) u_scale_right (
    .sample   (s1_right_r),
    .gain     (gain_sel),
    .scaled   (sc_right),
    .magnitude(mag_right)
  );

  assign cfg_ready = 1'b1;
  assign advance = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || advance;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_fire)
      s1_vld_nxt = 1'b1;
    else if (advance)
      s1_vld_nxt = 1'b0;

    out_vld_nxt = out_vld_r;
    if (advance)
      out_vld_nxt = s1_vld_r;
    else if (out_ready)
      out_vld_nxt = 1'b0;
  end

  always_comb begin
    pk = peak_r;
    if (mag_left > pk)
      pk = mag_left;
    if (mag_right > pk)
      pk = mag_right;
    cnt_inc = (count_r == '1) ? count_r : count_r + COUNT_W'(1);
    pk25 = (PK25_W'(pk) << 4) + (PK25_W'(pk) << 3) + PK25_W'(pk);

    count_nxt = count_r;
    peak_nxt = peak_r;
    dec_nxt = dec_r;
    out_left_nxt = sc_left;
    out_right_nxt = sc_right;
    out_peak_nxt = pk;
    out_last_nxt = s1_last_r;

    if (s1_vld_r && advance) begin
      if (s1_cmd_r == CMD_RESTART) begin
        count_nxt = '0;
        peak_nxt = '0;
        dec_nxt = BOOST_UNDECIDED;
        out_left_nxt = '0;
        out_right_nxt = '0;
        out_peak_nxt = '0;
        out_last_nxt = 1'b0;
      end else begin
        count_nxt = cnt_inc;
        peak_nxt = pk;
        if (s1_last_r) begin
          // decide once a quarter second has gone by
          if (ctl.boost_en && dec_r == BOOST_UNDECIDED &&
              {cnt_inc, 2'b00} >= (COUNT_W + 2)'(ctl.sample_rate)) begin
            if (pk != '0 && pk25 < BOOST_THR)
              dec_nxt = BOOST_ON;
            else
              dec_nxt = BOOST_DECLINED;
          end
          peak_nxt = '0;
        end
      end
    end
    if (ctl.dec_clr)
      dec_nxt = BOOST_UNDECIDED;
    out_status_nxt = dec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      count_r <= '0;
      peak_r <= '0;
      dec_r <= BOOST_UNDECIDED;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      count_r <= count_nxt;
      peak_r <= peak_nxt;
      dec_r <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_cmd;
      s1_left_r <= in_left_sample;
      s1_right_r <= in_right_sample;
      s1_last_r <= in_block_end;
    end
    if (s1_vld_r && advance) begin
      out_left_r <= out_left_nxt;
      out_right_r <= out_right_nxt;
      out_peak_r <= out_peak_nxt;
      out_status_r <= out_status_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_left = out_left_r;
  assign out_right = out_right_r;
  assign out_peak_level = out_peak_r;
  assign out_boost_status = out_status_r;
  assign out_last = out_last_r;

endmodule
